### design/tcot_pkg.sv
// Package: shared constants, codes and types of the touch contact order tracker.
`timescale 1ns / 1ps
`default_nettype none
package tcot_pkg;

	// Number of hardware slots, and so of cells in the down list.
	localparam int MAX_SLOTS = 10;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 4;
	localparam int TYPE_W    = 8;
	localparam int POS_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_FINGERS = 2'd0,
		CFG_FINGER_CODE = 2'd1,
		CFG_STYLUS_CODE = 2'd2
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_SHIFT,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	// Operations applied to every cell of the down list in the same cycle.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_MARK,
		OP_SHIFT,
		OP_APPEND,
		OP_ROTATE
	} cell_op_t;

	// Contents of one down-list cell.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              occ;
		logic              kill;
	} entry_t;

	// Control broadcast to all cells.
	typedef struct packed {
		cell_op_t             op;
		logic [SLOT_W-1:0]    app_slot;
		logic [MAX_SLOTS-1:0] rm_mask;
	} cell_ctl_t;

	// Signals passed from one cell to the next along the chain.
	typedef struct packed {
		logic                 shift;
		logic                 occ;
		logic [MAX_SLOTS-1:0] seen;
	} link_t;

endpackage
`default_nettype wire

### design/tcot_if.sv
// Interfaces: item, result and configuration channels of the tracker.
`timescale 1ns / 1ps
`default_nettype none

// Input record channel.
interface tcot_in_if;
	logic                       valid;
	logic                       ready;
	logic [tcot_pkg::TYPE_W-1:0] object_type;
	logic [tcot_pkg::POS_W-1:0]  pos_x;
	logic [tcot_pkg::POS_W-1:0]  pos_y;

	modport source (output valid, output object_type, output pos_x, output pos_y,
		input ready);
	modport sink (input valid, input object_type, input pos_x, input pos_y,
		output ready);
endinterface

// Result channel.
interface tcot_out_if;
	logic                        valid;
	logic                        ready;
	logic [tcot_pkg::SLOT_W-1:0] slot_index;
	logic                        touching;
	logic [tcot_pkg::POS_W-1:0]  report_x;
	logic [tcot_pkg::POS_W-1:0]  report_y;
	logic                        last_contact;

	modport source (output valid, output slot_index, output touching, output report_x,
		output report_y, output last_contact, input ready);
	modport sink (input valid, input slot_index, input touching, input report_x,
		input report_y, input last_contact, output ready);
endinterface

// Configuration write channel.
interface tcot_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tcot_pkg::CFG_IDX_W-1:0] index;
	logic [tcot_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/tcot_cell.sv
// One cell of the down list: holds one slot entry and talks to its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module tcot_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tcot_pkg::cell_ctl_t ctl,
	input  wire tcot_pkg::link_t     prev,
	input  wire tcot_pkg::entry_t    nxt,
	output tcot_pkg::entry_t         ent,
	output tcot_pkg::link_t          link
);

	tcot_pkg::entry_t ent_q;
	logic             mark_kill;

	// Only the first occurrence of a slot due for removal is marked.
	always_comb begin
		mark_kill = ent_q.occ & ctl.rm_mask[ent_q.slot] & ~prev.seen[ent_q.slot];
		link.shift = prev.shift | ent_q.kill;
		link.occ   = ent_q.occ;
		link.seen  = prev.seen;
		if (ent_q.occ) begin
			link.seen = prev.seen | (tcot_pkg::MAX_SLOTS'(1) << ent_q.slot);
		end
	end

	// Cell register: each operation moves data at most one place along the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			unique case (ctl.op)
				tcot_pkg::OP_HOLD: begin
					ent_q <= ent_q;
				end
				tcot_pkg::OP_MARK: begin
					ent_q.kill <= mark_kill;
				end
				tcot_pkg::OP_SHIFT: begin
					if (link.shift) begin
						ent_q <= nxt;
					end
				end
				tcot_pkg::OP_APPEND: begin
					if (!ent_q.occ && prev.occ) begin
						ent_q.slot <= ctl.app_slot;
						ent_q.occ  <= 1'b1;
						ent_q.kill <= 1'b0;
					end
				end
				tcot_pkg::OP_ROTATE: begin
					ent_q <= nxt;
				end
				default: begin
					ent_q <= ent_q;
				end
			endcase
		end
	end

	assign ent = ent_q;

endmodule
`default_nettype wire

### design/touch_contact_order_tracker.sv
// Top level: touch contact order tracker with its down-list chain and slot cache.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one object record per word for slots 0 to max_fingers-1 (clamped to
// one through ten) of a frame and keeps the contacts in touch-down order in a chain of ten
// cells. An ordinary record is accepted and then updated. The first record of a frame
// first passes a marking step, then a shift step that removes one lifted contact from the
// chain at a time until none is left. When the list is not empty, the last record of a
// frame is followed by a full rotation of the chain, during which one result word is
// loaded for each occupied cell as it reaches the head; the rotation waits while a result
// word still to be loaded meets a stalled result port. A new record is taken only once the
// report has finished; a final result word may still wait at the output while that record
// is accepted. Configuration writes are taken only while the block is idle between records.
module touch_contact_order_tracker (
	input  wire logic clk,
	input  wire logic arst_n,
	tcot_cfg_if.sink  cfg,
	tcot_in_if.sink   items_in,
	tcot_out_if.source results
);

	localparam int NS = tcot_pkg::MAX_SLOTS;

	// Configuration registers.
	logic [tcot_pkg::CNT_W-1:0]  max_fingers_q;
	logic [tcot_pkg::TYPE_W-1:0] finger_code_q;
	logic [tcot_pkg::TYPE_W-1:0] stylus_code_q;

	// Tracking state.
	tcot_pkg::state_t             state_q, state_d;
	logic [tcot_pkg::CNT_W-1:0]   slot_cnt_q;
	logic [NS-1:0]                valid_q;
	logic [NS-1:0]                lifted_q;
	logic [tcot_pkg::CNT_W-1:0]   count_q;
	logic [tcot_pkg::CNT_W-1:0]   k_q;
	logic [tcot_pkg::SLOT_W-1:0]  s_q;
	logic [tcot_pkg::TYPE_W-1:0]  type_q;
	logic [tcot_pkg::POS_W-1:0]   px_q;
	logic [tcot_pkg::POS_W-1:0]   py_q;

	// Per-slot cache of the last reported state.
	logic                         touch_q [NS];
	logic [tcot_pkg::POS_W-1:0]   sx_q [NS];
	logic [tcot_pkg::POS_W-1:0]   sy_q [NS];

	// Output register.
	logic                         ov_q;
	logic [tcot_pkg::SLOT_W-1:0]  o_slot_q;
	logic                         o_touch_q;
	logic [tcot_pkg::POS_W-1:0]   o_x_q;
	logic [tcot_pkg::POS_W-1:0]   o_y_q;
	logic                         o_last_q;

	// Chain signals.
	tcot_pkg::cell_ctl_t          ctl;
	tcot_pkg::entry_t             ents  [NS];
	tcot_pkg::link_t              links [NS];
	tcot_pkg::entry_t             tail_in;
	tcot_pkg::link_t              head_link;
	logic [NS-1:0]                occ_vec;

	logic [tcot_pkg::CNT_W-1:0]   n_act;
	logic [NS-1:0]                low_mask;
	logic [tcot_pkg::SLOT_W-1:0]  s_new;
	logic                         accept;
	logic                         present;
	logic                         app;
	logic                         frame_end;
	logic                         emit_now;
	logic                         out_free;
	logic                         step;
	logic                         any_kill;
	logic [tcot_pkg::CNT_W-1:0]   count_upd;

	// Slot count in use, clamped to one through the number of slots.
	always_comb begin
		if (max_fingers_q == '0) begin
			n_act = tcot_pkg::CNT_W'(1);
		end else if (max_fingers_q > tcot_pkg::CNT_W'(NS)) begin
			n_act = tcot_pkg::CNT_W'(NS);
		end else begin
			n_act = max_fingers_q;
		end
		for (int i = 0; i < NS; i++) begin
			low_mask[i] = (tcot_pkg::CNT_W'(i) < n_act);
			occ_vec[i]  = ents[i].occ;
		end
	end

	assign accept    = items_in.valid & items_in.ready;
	assign s_new     = (slot_cnt_q >= n_act) ? '0 : slot_cnt_q;
	assign present   = (type_q == finger_code_q) || (type_q == stylus_code_q);
	assign app       = present & ~valid_q[s_q] & (count_q < n_act);
	assign frame_end = (s_q >= n_act - tcot_pkg::CNT_W'(1));
	assign count_upd = count_q + tcot_pkg::CNT_W'(app);
	assign emit_now  = (k_q < count_q);
	assign out_free  = ~ov_q | results.ready;
	assign step      = ~emit_now | out_free;
	assign any_kill  = links[NS-1].shift;

	// Next state and cell control.
	always_comb begin
		state_d        = state_q;
		items_in.ready = 1'b0;
		ctl.op         = tcot_pkg::OP_HOLD;
		ctl.app_slot   = s_q;
		ctl.rm_mask    = lifted_q & low_mask;
		unique case (state_q)
			tcot_pkg::ST_IDLE: begin
				items_in.ready = 1'b1;
				if (items_in.valid) begin
					state_d = (s_new == '0) ? tcot_pkg::ST_MARK : tcot_pkg::ST_UPDATE;
				end
			end
			tcot_pkg::ST_MARK: begin
				ctl.op  = tcot_pkg::OP_MARK;
				state_d = tcot_pkg::ST_SHIFT;
			end
			tcot_pkg::ST_SHIFT: begin
				ctl.op = tcot_pkg::OP_SHIFT;
				if (!any_kill) begin
					state_d = tcot_pkg::ST_UPDATE;
				end
			end
			tcot_pkg::ST_UPDATE: begin
				if (app) begin
					ctl.op = tcot_pkg::OP_APPEND;
				end
				if (frame_end && count_upd != '0) begin
					state_d = tcot_pkg::ST_EMIT;
				end else begin
					state_d = tcot_pkg::ST_IDLE;
				end
			end
			tcot_pkg::ST_EMIT: begin
				if (step) begin
					ctl.op = tcot_pkg::OP_ROTATE;
					if (k_q == tcot_pkg::CNT_W'(NS - 1)) begin
						state_d = tcot_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = tcot_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcot_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes, taken while idle; indexes beyond the list are ignored.
	assign cfg.ready = (state_q == tcot_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fingers_q <= tcot_pkg::CNT_W'(10);
			finger_code_q <= tcot_pkg::TYPE_W'(1);
			stylus_code_q <= tcot_pkg::TYPE_W'(2);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tcot_pkg::CFG_MAX_FINGERS: max_fingers_q <= cfg.data[tcot_pkg::CNT_W-1:0];
				tcot_pkg::CFG_FINGER_CODE: finger_code_q <= cfg.data;
				tcot_pkg::CFG_STYLUS_CODE: stylus_code_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Slot counter, presence masks, list length and report counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q <= '0;
			valid_q    <= '0;
			lifted_q   <= '0;
			count_q    <= '0;
			k_q        <= '0;
		end else begin
			unique case (state_q)
				tcot_pkg::ST_IDLE: begin
					k_q <= '0;
				end
				tcot_pkg::ST_MARK: begin
					lifted_q <= lifted_q & ~low_mask;
				end
				tcot_pkg::ST_SHIFT: begin
					if (any_kill) begin
						count_q <= count_q - tcot_pkg::CNT_W'(1);
					end
				end
				tcot_pkg::ST_UPDATE: begin
					count_q <= count_upd;
					if (valid_q[s_q] || app) begin
						if (present) begin
							valid_q[s_q] <= 1'b1;
						end else begin
							valid_q[s_q]  <= 1'b0;
							lifted_q[s_q] <= 1'b1;
						end
					end
					slot_cnt_q <= frame_end ? '0 : s_q + tcot_pkg::CNT_W'(1);
				end
				tcot_pkg::ST_EMIT: begin
					if (step) begin
						k_q <= k_q + tcot_pkg::CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Latched record.
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= s_new;
			type_q <= items_in.object_type;
			px_q   <= items_in.pos_x;
			py_q   <= items_in.pos_y;
		end
	end

	// Slot cache: written for a tracked slot; position only while present.
	always_ff @(posedge clk) begin
		if (state_q == tcot_pkg::ST_UPDATE && (valid_q[s_q] || app)) begin
			touch_q[s_q] <= present;
			if (present) begin
				sx_q[s_q] <= px_q;
				sy_q[s_q] <= py_q;
			end
		end
	end

	// Down-list chain; the tail takes the head during a rotation, else an empty entry.
	assign head_link.shift = 1'b0;
	assign head_link.occ   = 1'b1;
	assign head_link.seen  = '0;
	assign tail_in = (ctl.op == tcot_pkg::OP_ROTATE) ? ents[0] : '0;

	for (genvar j = 0; j < NS; j++) begin : g_cell
		if (j == 0) begin : g_first
			if (NS == 1) begin : g_only
				tcot_cell u_cell (.clk, .arst_n, .ctl, .prev(head_link), .nxt(tail_in),
					.ent(ents[j]), .link(links[j]));
			end else begin : g_more
				tcot_cell u_cell (.clk, .arst_n, .ctl, .prev(head_link), .nxt(ents[j+1]),
					.ent(ents[j]), .link(links[j]));
			end
		end else if (j == NS - 1) begin : g_last
			tcot_cell u_cell (.clk, .arst_n, .ctl, .prev(links[j-1]), .nxt(tail_in),
				.ent(ents[j]), .link(links[j]));
		end else begin : g_mid
			tcot_cell u_cell (.clk, .arst_n, .ctl, .prev(links[j-1]), .nxt(ents[j+1]),
				.ent(ents[j]), .link(links[j]));
		end
	end

	// Output register: loaded from the head cell while the chain rotates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == tcot_pkg::ST_EMIT && step && emit_now) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcot_pkg::ST_EMIT && step && emit_now) begin
			o_slot_q  <= ents[0].slot;
			o_touch_q <= touch_q[ents[0].slot];
			o_x_q     <= sx_q[ents[0].slot];
			o_y_q     <= sy_q[ents[0].slot];
			o_last_q  <= (k_q + tcot_pkg::CNT_W'(1) == count_q);
		end
	end

	assign results.valid        = ov_q;
	assign results.slot_index   = o_slot_q;
	assign results.touching     = o_touch_q;
	assign results.report_x     = o_x_q;
	assign results.report_y     = o_y_q;
	assign results.last_contact = o_last_q;

	// The list length always matches the number of occupied cells.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == 32'(count_q))
		else $error("list length differs from occupied cells");

	// The list never grows beyond the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tcot_pkg::CNT_W'(NS))
		else $error("list length beyond slot count");

	// No removal mark survives into the idle state.
	a_no_kill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		items_in.ready |-> !any_kill)
		else $error("removal pending while taking a record");

	// A result word only appears after a report cycle.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(state_q == tcot_pkg::ST_EMIT))
		else $error("result word outside a report");

endmodule
`default_nettype wire
